// ===== design/assert_macros.svh =====
// assertion macros used by the csvp_checker file
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising edge outside reset
`define ASSERT_AT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// expression must never be true at a rising edge outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
  `ASSERT_AT(lbl, clk, rst_n, !(expr))

`endif

// ===== design/csvp_pkg.sv =====
// types and codes for the csv stream parser
// no dependencies; imported by csv_stream_parser and its checker
package csvp_pkg;

  // input actions
  localparam logic ACT_BYTE = 1'b0;
  localparam logic ACT_END  = 1'b1;

  // result kinds
  localparam logic [2:0] KIND_BYTE       = 3'd0;
  localparam logic [2:0] KIND_FIELD_END  = 3'd1;
  localparam logic [2:0] KIND_RECORD_END = 3'd2;
  localparam logic [2:0] KIND_ERROR      = 3'd3;
  localparam logic [2:0] KIND_DONE       = 3'd4;

  // error codes
  localparam logic [2:0] ERR_NONE         = 3'd0;
  localparam logic [2:0] ERR_QUOTE_UNQ    = 3'd1;
  localparam logic [2:0] ERR_AFTER_QUOTE  = 3'd2;
  localparam logic [2:0] ERR_BARE_CR      = 3'd3;
  localparam logic [2:0] ERR_COUNT        = 3'd4;
  localparam logic [2:0] ERR_UNTERMINATED = 3'd5;

  // special characters
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_NUL   = 8'h00;

  typedef struct packed {
    logic       action;
    logic [7:0] byte_value;
  } csvp_in_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  data_byte;
    logic [5:0]  field_index;
    logic [7:0]  field_length;
    logic [6:0]  field_count;
    logic [31:0] rec_number;
    logic [2:0]  error_code;
    logic        last;
  } csvp_out_t;

endpackage

// ===== design/csv_stream_parser.sv =====
// csv stream parser top level: rfc 4180 state machine with result buffer
// depends on csvp_pkg
//
//   channel | signals                           | beat
//   --------+-----------------------------------+-----------------------------------
//   in      | in_valid_i, in_ready_o, in_data_i   | one byte or end of input
//   out     | out_valid_o, out_ready_i, out_data_o| one result (byte, ends, error, done)
//
// one input beat is taken per cycle; its zero to three results are written
// together into a three-slot result buffer, shown from the next cycle on and
// drained one beat per cycle while out_ready_i is high, so bytes with at most
// one result run back to back and after a beat with k results the next beat
// waits until k-1 of them are taken; in_ready_o rises already in the cycle the
// last pending result is taken; reset clears parser state and the buffer at once
module csv_stream_parser #(
  parameter int MAX_FIELDS    = 64,
  parameter int MAX_FIELD_LEN = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  csvp_pkg::csvp_in_t in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output csvp_pkg::csvp_out_t out_data_o
);
  import csvp_pkg::*;

  // counter widths follow the limits
  localparam int CNT_W = $clog2(MAX_FIELDS + 1);
  localparam int LEN_W = (MAX_FIELD_LEN > 2) ? $clog2(MAX_FIELD_LEN) : 1;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_FIELDS);
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_FIELD_LEN - 1);

  // parser states
  localparam logic [3:0] S_MAIN         = 4'd0;
  localparam logic [3:0] S_QUOTED       = 4'd1;
  localparam logic [3:0] S_AFTER_QUOTE  = 4'd2;
  localparam logic [3:0] S_UNQUOTED     = 4'd3;
  localparam logic [3:0] S_AFTER_FIELD  = 4'd4;
  localparam logic [3:0] S_CR0          = 4'd5;
  localparam logic [3:0] S_CR1          = 4'd6;
  localparam logic [3:0] S_AFTER_FLD_CR = 4'd7;
  localparam logic [3:0] S_ERROR        = 4'd8;

  // parser state
  logic [3:0]       state_q, state_d;
  logic [LEN_W-1:0] len_q, len_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [CNT_W-1:0] exp_q, exp_d;
  logic             have_exp_q, have_exp_d;
  logic [31:0]      rec_q, rec_d;

  // result buffer
  csvp_out_t slot_q [3];
  csvp_out_t slot_d [3];
  logic [1:0] num_q, num_d;
  logic [1:0] rd_q;

  logic in_fire, out_fire;

  function automatic csvp_out_t make_res(logic [2:0] kind, logic [7:0] data,
                                         logic [5:0] idx, logic [7:0] flen,
                                         logic [6:0] fcnt, logic [31:0] line,
                                         logic [2:0] err);
    csvp_out_t r;
    r.kind         = kind;
    r.data_byte    = data;
    r.field_index  = idx;
    r.field_length = flen;
    r.field_count  = fcnt;
    r.rec_number   = line;
    r.error_code   = err;
    r.last         = 1'b0;
    return r;
  endfunction

  // handshake: accept when the buffer is empty or its last result leaves now
  assign out_valid_o = (rd_q != num_q);
  assign out_fire    = out_valid_o && out_ready_i;
  assign in_ready_o  = !out_valid_o || (out_ready_i && ((rd_q + 2'd1) == num_q));
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_data_o  = slot_q[rd_q];

  // per-beat decode and result generation
  always_comb begin
    logic       is_lf, is_cr, is_cm, is_qt, is_nul;
    logic       do_add, do_ef, do_er, do_raise, do_done;
    logic [7:0] add_val;
    logic [2:0] raise_code;
    logic [1:0] n;

    state_d    = state_q;
    len_d      = len_q;
    cnt_d      = cnt_q;
    exp_d      = exp_q;
    have_exp_d = have_exp_q;
    rec_d      = rec_q;
    slot_d     = slot_q;

    is_lf  = (in_data_i.byte_value == CH_LF);
    is_cr  = (in_data_i.byte_value == CH_CR);
    is_cm  = (in_data_i.byte_value == CH_COMMA);
    is_qt  = (in_data_i.byte_value == CH_QUOTE);
    is_nul = (in_data_i.byte_value == CH_NUL);

    do_add     = 1'b0;
    do_ef      = 1'b0;
    do_er      = 1'b0;
    do_raise   = 1'b0;
    do_done    = 1'b0;
    add_val    = in_data_i.byte_value;
    raise_code = ERR_NONE;
    n          = 2'd0;

    if (in_data_i.action == ACT_END) begin
      do_done = 1'b1;
      case (state_q)
        S_UNQUOTED, S_AFTER_FIELD, S_AFTER_QUOTE: begin
          do_ef = 1'b1;
          do_er = 1'b1;
        end
        S_MAIN, S_ERROR: begin
        end
        default: begin
          do_raise   = 1'b1;
          raise_code = ERR_UNTERMINATED;
        end
      endcase
    end else begin
      case (state_q)
        S_MAIN, S_AFTER_FIELD: begin
          if (is_lf) begin
            do_ef = (state_q == S_AFTER_FIELD);
            do_er = 1'b1;
          end else if (is_cr) begin
            if (state_q == S_AFTER_FIELD) begin
              do_ef   = 1'b1;
              state_d = S_AFTER_FLD_CR;
            end else begin
              state_d = S_CR0;
            end
          end else if (is_cm) begin
            do_ef   = 1'b1;
            state_d = S_AFTER_FIELD;
          end else if (is_qt) begin
            state_d = S_QUOTED;
          end else begin
            do_add  = !is_nul;
            state_d = S_UNQUOTED;
          end
        end
        S_QUOTED: begin
          if (is_qt) begin
            state_d = S_AFTER_QUOTE;
          end else begin
            do_add = !is_nul;
          end
        end
        S_AFTER_QUOTE, S_UNQUOTED: begin
          if (is_lf) begin
            do_ef = 1'b1;
            do_er = 1'b1;
          end else if (is_cr) begin
            state_d = S_CR1;
          end else if (is_cm) begin
            do_ef   = 1'b1;
            state_d = S_AFTER_FIELD;
          end else if (state_q == S_AFTER_QUOTE) begin
            if (is_qt) begin
              // doubled quote gives one quote
              do_add  = 1'b1;
              add_val = CH_QUOTE;
              state_d = S_QUOTED;
            end else begin
              do_raise   = 1'b1;
              raise_code = ERR_AFTER_QUOTE;
            end
          end else if (is_qt) begin
            do_raise   = 1'b1;
            raise_code = ERR_QUOTE_UNQ;
          end else begin
            do_add = !is_nul;
          end
        end
        S_CR0, S_CR1, S_AFTER_FLD_CR: begin
          if (is_lf) begin
            do_ef = (state_q == S_CR1);
            do_er = 1'b1;
          end else begin
            do_raise   = 1'b1;
            raise_code = ERR_BARE_CR;
          end
        end
        default: begin
          // latched error: bytes are swallowed
        end
      endcase
    end

    // content byte, kept only below the length limit
    if (do_add && (len_d < LEN_MAX)) begin
      len_d = len_d + LEN_W'(1);
      if (cnt_d < CNT_MAX) begin
        slot_d[n] = make_res(KIND_BYTE, add_val, 6'(cnt_d), 8'd0, 7'd0, rec_d,
                             ERR_NONE);
        n = n + 2'd1;
      end
    end

    // field end, dropped past the field limit
    if (do_ef) begin
      if (cnt_d < CNT_MAX) begin
        slot_d[n] = make_res(KIND_FIELD_END, 8'd0, 6'(cnt_d), 8'(len_d), 7'd0,
                             rec_d, ERR_NONE);
        n = n + 2'd1;
        cnt_d = cnt_d + CNT_W'(1);
      end
      len_d = '0;
    end

    // record end; the first record fixes the expected count
    if (do_er) begin
      if (have_exp_d && (cnt_d != exp_d)) begin
        do_raise   = 1'b1;
        raise_code = ERR_COUNT;
      end else begin
        if (!have_exp_d) begin
          exp_d      = cnt_d;
          have_exp_d = 1'b1;
        end
        slot_d[n] = make_res(KIND_RECORD_END, 8'd0, 6'd0, 8'd0, 7'(cnt_d), rec_d,
                             ERR_NONE);
        n = n + 2'd1;
        cnt_d   = '0;
        len_d   = '0;
        rec_d   = rec_d + 32'd1;
        state_d = S_MAIN;
      end
    end

    if (do_raise) begin
      slot_d[n] = make_res(KIND_ERROR, 8'd0, 6'd0, 8'd0, 7'd0, rec_d, raise_code);
      n = n + 2'd1;
      state_d = S_ERROR;
    end

    // end of input: report, then back to reset values
    if (do_done) begin
      slot_d[n] = make_res(KIND_DONE, 8'd0, 6'd0, 8'd0, 7'd0, rec_d, ERR_NONE);
      n = n + 2'd1;
      state_d    = S_MAIN;
      len_d      = '0;
      cnt_d      = '0;
      exp_d      = '0;
      have_exp_d = 1'b0;
      rec_d      = 32'd1;
    end

    if (n != 2'd0) begin
      slot_d[n - 2'd1].last = 1'b1;
    end
    num_d = n;
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_MAIN;
      len_q      <= '0;
      cnt_q      <= '0;
      exp_q      <= '0;
      have_exp_q <= 1'b0;
      rec_q      <= 32'd1;
      num_q      <= 2'd0;
      rd_q       <= 2'd0;
    end else if (in_fire) begin
      state_q    <= state_d;
      len_q      <= len_d;
      cnt_q      <= cnt_d;
      exp_q      <= exp_d;
      have_exp_q <= have_exp_d;
      rec_q      <= rec_d;
      num_q      <= num_d;
      rd_q       <= 2'd0;
    end else if (out_fire) begin
      rd_q <= rd_q + 2'd1;
    end
  end

  // result payload, loaded with every accepted beat
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      slot_q <= slot_d;
    end
  end

endmodule

// ===== design/csvp_checker.sv =====
// port-level checker for csv_stream_parser, attached by bind
// depends on csvp_pkg and assert_macros.svh
`include "assert_macros.svh"

module csvp_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input csvp_pkg::csvp_out_t out_data_o
);
  import csvp_pkg::*;

  // a stalled result beat holds
  `ASSERT_AT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))

  // input only stalls while results are pending
  `ASSERT_AT(a_stall_has_results, clk_i, rst_ni, !in_ready_o |-> out_valid_o)

  // results of one input follow without gaps until last
  `ASSERT_AT(a_burst_contiguous, clk_i, rst_ni, out_valid_o && out_ready_i && !out_data_o.last |=> out_valid_o)

  // input done always closes its burst
  `ASSERT_NEVER(a_done_is_last, clk_i, rst_ni, out_valid_o && (out_data_o.kind == KIND_DONE) && !out_data_o.last)

  // no kind code outside the defined set
  `ASSERT_NEVER(a_kind_range, clk_i, rst_ni, out_valid_o && (out_data_o.kind > KIND_DONE))

endmodule

bind csv_stream_parser csvp_checker u_csvp_checker (.*);
